// ===== hw/rtl/qlm_pkg.sv =====
// ---------------------------------------------------------------------------
// qlm_pkg: shared types and constants of the quadrature length meter
// Field widths, command encoding, register indexes and FSM states.
// ---------------------------------------------------------------------------
package qlm_pkg;

   localparam int OP_W      = 2;
   localparam int CFG_W     = 14;
   localparam int CSR_IDX_W = 4;
   localparam int LEN_W     = 20;
   localparam int RST_W     = 17;
   localparam int SPD_W     = 10;
   localparam int CNT_W     = 14;
   localparam int TICK_W    = 17;
   localparam int IDLE_W    = 8;
   localparam int DIV_W     = 17;

   localparam int LENGTH_MAX_DEF = 999999;
   localparam int IDLE_LIMIT_DEF = 200;
   localparam int FIFO_DEPTH_DEF = 2;

   // input opcodes
   localparam logic [OP_W-1:0] OP_PIN   = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] REG_TARGET  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WARNING = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CIRC    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PULSES  = 4'd3;

   localparam logic [CFG_W-1:0] CFG_MAX        = 14'd9999;
   localparam logic [CFG_W-1:0] TARGET_RESET   = 14'd999;
   localparam logic [CFG_W-1:0] WARNING_RESET  = 14'd989;
   localparam logic [CFG_W-1:0] CIRC_RESET     = 14'd500;
   localparam logic [CFG_W-1:0] PULSES_RESET   = 14'd4;

   localparam logic [LEN_W:0]   OVERSHOOT_LIMIT = 21'd1000010;
   localparam logic [SPD_W-1:0] SPEED_MAX       = 10'd999;
   localparam logic [RST_W-1:0] RESETS_MAX      = 17'd99999;
   localparam logic [6:0]       THRESH_SCALE    = 7'd100;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_ARM,
      CMD_FWD,
      CMD_BACK,
      CMD_DISARM,
      CMD_TICK,
      CMD_CLEAR
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP_DIV,
      ST_CHECK,
      ST_SPEED_DIV,
      ST_PUSH
   } back_state_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     data;
   } csr_write_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [LEN_W-1:0] previous_length;
      logic [RST_W-1:0] reset_count;
      logic [SPD_W-1:0] speed;
      logic             full_relay;
      logic             warning_relay;
      logic             armed;
   } rsp_word_type;

endpackage

// ===== hw/rtl/qlm_fifo.sv =====
// ---------------------------------------------------------------------------
// qlm_fifo: small flop-based word queue
// Push/pop queue with full and empty flags; head word shown while not empty.
// ---------------------------------------------------------------------------
module qlm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/qlm_div.sv =====
// ---------------------------------------------------------------------------
// qlm_div: iterative unsigned divider
// Restoring divide, one quotient bit per cycle; done pulses with the result.
// ---------------------------------------------------------------------------
module qlm_div (
   input  logic                    clock,
   input  logic                    reset,
   input  qlm_pkg::div_req_type    req,
   output logic                    done,
   output logic [qlm_pkg::DIV_W-1:0] quotient
);
   import qlm_pkg::*;

   localparam int CntW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted;

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign shifted  = {rem_ff, quo_ff[DIV_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         den_in = req.divisor;
         cnt_in = CntW'(DIV_W);
      end else if (cnt_ff != '0) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DIV_W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

// ===== hw/rtl/qlm_front.sv =====
// ---------------------------------------------------------------------------
// qlm_front: input word intake and classification
// Decodes opcode and pin levels into a command and queues it for the back.
// ---------------------------------------------------------------------------
module qlm_front #(
   parameter int DEPTH = qlm_pkg::FIFO_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [qlm_pkg::OP_W-1:0]    req_opcode,
   input  logic                        req_pin_a,
   input  logic                        req_pin_b,
   input  logic                        cmd_pop,
   output logic                        cmd_empty,
   output qlm_pkg::cmd_kind_type       cmd_kind
);
   import qlm_pkg::*;

   localparam int KindW = $bits(cmd_kind_type);

   cmd_kind_type     kind;
   logic [KindW-1:0] head_bits;

   always_comb begin
      kind = CMD_NOP;
      case (req_opcode)
         OP_PIN: begin
            case ({req_pin_a, req_pin_b})
               2'b00:   kind = CMD_ARM;
               2'b01:   kind = CMD_FWD;
               2'b10:   kind = CMD_BACK;
               default: kind = CMD_DISARM;
            endcase
         end
         OP_TICK:  kind = CMD_TICK;
         OP_CLEAR: kind = CMD_CLEAR;
         OP_NONE:  kind = CMD_NOP;
         default:  kind = CMD_NOP;
      endcase
   end

   qlm_fifo #(
      .WIDTH (KindW),
      .DEPTH (DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (kind),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (head_bits),
      .empty     (cmd_empty)
   );

   assign cmd_kind = cmd_kind_type'(head_bits);

endmodule

// ===== hw/rtl/qlm_back.sv =====
// ---------------------------------------------------------------------------
// qlm_back: command execution
// Holds config and meter state, runs step and speed divides, emits results.
// ---------------------------------------------------------------------------
module qlm_back #(
   parameter int LENGTH_MAX = qlm_pkg::LENGTH_MAX_DEF,
   parameter int IDLE_LIMIT = qlm_pkg::IDLE_LIMIT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  qlm_pkg::csr_write_type  csr,
   input  logic                    cmd_empty,
   input  qlm_pkg::cmd_kind_type   cmd_kind,
   output logic                    cmd_pop,
   input  logic                    rsp_full,
   output logic                    rsp_push,
   output qlm_pkg::rsp_word_type   rsp_word
);
   import qlm_pkg::*;

   localparam logic [LEN_W-1:0]  LenMax    = LEN_W'(LENGTH_MAX);
   localparam logic [IDLE_W-1:0] IdleLimit = IDLE_W'(IDLE_LIMIT);

   back_state_type   state_ff, state_in;
   logic [CFG_W-1:0] target_ff, target_in;
   logic [CFG_W-1:0] warning_ff, warning_in;
   logic [CFG_W-1:0] circ_ff, circ_in;
   logic [CFG_W-1:0] pulses_ff, pulses_in;
   logic [CFG_W-1:0] step_ff, step_in;
   logic             step_dirty_ff, step_dirty_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] saved_ff, saved_in;
   logic [RST_W-1:0] resets_ff, resets_in;
   logic             arm_ff, arm_in;
   logic [CNT_W-1:0] counts_ff, counts_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;
   logic [SPD_W-1:0] speed_ff, speed_in;

   div_req_type      div_req;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;

   logic [LEN_W:0]   fwd_sum;
   logic [LEN_W-1:0] fwd_len;
   logic [LEN_W-1:0] back_len;
   logic [LEN_W-1:0] step_ext;
   logic             idle_hit;
   logic [CNT_W-1:0] counts_eff;
   logic [LEN_W-1:0] target_scaled;
   logic [LEN_W-1:0] warning_scaled;

   // length update candidates
   assign step_ext = LEN_W'(step_ff);
   assign fwd_sum  = {1'b0, length_ff} + {1'b0, step_ext};
   always_comb begin
      if (fwd_sum > OVERSHOOT_LIMIT) begin
         fwd_len = '0;
      end else if (fwd_sum > {1'b0, LenMax}) begin
         fwd_len = LenMax;
      end else begin
         fwd_len = fwd_sum[LEN_W-1:0];
      end
   end
   assign back_len = (step_ext > length_ff) ? '0 : length_ff - step_ext;

   assign idle_hit   = (idle_ff >= IdleLimit);
   assign counts_eff = idle_hit ? '0 : counts_ff;

   assign target_scaled  = LEN_W'(target_ff) * LEN_W'(THRESH_SCALE);
   assign warning_scaled = LEN_W'(warning_ff) * LEN_W'(THRESH_SCALE);

   always_comb begin
      rsp_word.length          = length_ff;
      rsp_word.previous_length = saved_ff;
      rsp_word.reset_count     = resets_ff;
      rsp_word.speed           = speed_ff;
      rsp_word.full_relay      = (length_ff >= target_scaled);
      rsp_word.warning_relay   = (length_ff >= warning_scaled);
      rsp_word.armed           = arm_ff;
   end

   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      warning_in    = warning_ff;
      circ_in       = circ_ff;
      pulses_in     = pulses_ff;
      step_in       = step_ff;
      step_dirty_in = step_dirty_ff;
      length_in     = length_ff;
      saved_in      = saved_ff;
      resets_in     = resets_ff;
      arm_in        = arm_ff;
      counts_in     = counts_ff;
      ticks_in      = ticks_ff;
      idle_in       = idle_ff;
      speed_in      = speed_ff;
      div_req       = '0;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (step_dirty_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(circ_ff);
               div_req.divisor  = DIV_W'(pulses_ff);
               step_dirty_in    = 1'b0;
               state_in         = ST_STEP_DIV;
            end else if (!cmd_empty && !rsp_full) begin
               cmd_pop  = 1'b1;
               state_in = ST_CHECK;
               case (cmd_kind)
                  CMD_ARM: arm_in = 1'b1;
                  CMD_FWD: begin
                     if (arm_ff) begin
                        length_in = fwd_len;
                        counts_in = (counts_ff != '1) ? counts_ff + 1'b1 : counts_ff;
                        idle_in   = '0;
                     end
                  end
                  CMD_BACK: begin
                     if (arm_ff) begin
                        length_in = back_len;
                        counts_in = (counts_ff != '1) ? counts_ff + 1'b1 : counts_ff;
                        idle_in   = '0;
                     end
                  end
                  CMD_DISARM: arm_in = 1'b0;
                  CMD_TICK: begin
                     ticks_in = (ticks_ff != '1) ? ticks_ff + 1'b1 : ticks_ff;
                     idle_in  = (idle_ff != '1) ? idle_ff + 1'b1 : idle_ff;
                  end
                  CMD_CLEAR: begin
                     if (length_ff != '0) begin
                        saved_in = length_ff;
                     end
                     resets_in = (resets_ff < RESETS_MAX) ? resets_ff + 1'b1 : resets_ff;
                     length_in = '0;
                     speed_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_STEP_DIV: begin
            if (div_done) begin
               step_in  = div_quo[CFG_W-1:0];
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            state_in = ST_PUSH;
            if (idle_hit) begin
               counts_in = '0;
               speed_in  = '0;
            end
            if (counts_eff >= pulses_ff) begin
               counts_in = '0;
               ticks_in  = '0;
               if (ticks_ff == '0) begin
                  speed_in = SPEED_MAX;
               end else begin
                  // 12 * circumference as two shifted terms
                  div_req.start    = 1'b1;
                  div_req.dividend = (DIV_W'(circ_ff) << 3) + (DIV_W'(circ_ff) << 2);
                  div_req.divisor  = DIV_W'(ticks_ff);
                  state_in         = ST_SPEED_DIV;
               end
            end
         end
         ST_SPEED_DIV: begin
            if (div_done) begin
               speed_in = (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[SPD_W-1:0];
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // register writes; out-of-range values fall back to reset values
      if (csr.valid) begin
         case (csr.index)
            REG_TARGET:  target_in  = (csr.data > CFG_MAX) ? TARGET_RESET : csr.data;
            REG_WARNING: warning_in = (csr.data > CFG_MAX) ? WARNING_RESET : csr.data;
            REG_CIRC: begin
               circ_in = (csr.data > CFG_MAX || csr.data == '0) ? CIRC_RESET : csr.data;
               step_dirty_in = 1'b1;
            end
            REG_PULSES: begin
               pulses_in = (csr.data > CFG_MAX || csr.data == '0) ? PULSES_RESET : csr.data;
               step_dirty_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         target_ff     <= TARGET_RESET;
         warning_ff    <= WARNING_RESET;
         circ_ff       <= CIRC_RESET;
         pulses_ff     <= PULSES_RESET;
         step_ff       <= '0;
         step_dirty_ff <= 1'b1;
         length_ff     <= '0;
         saved_ff      <= '0;
         resets_ff     <= '0;
         arm_ff        <= 1'b0;
         counts_ff     <= '0;
         ticks_ff      <= '0;
         idle_ff       <= '0;
         speed_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         target_ff     <= target_in;
         warning_ff    <= warning_in;
         circ_ff       <= circ_in;
         pulses_ff     <= pulses_in;
         step_ff       <= step_in;
         step_dirty_ff <= step_dirty_in;
         length_ff     <= length_in;
         saved_ff      <= saved_in;
         resets_ff     <= resets_in;
         arm_ff        <= arm_in;
         counts_ff     <= counts_in;
         ticks_ff      <= ticks_in;
         idle_ff       <= idle_in;
         speed_ff      <= speed_in;
      end
   end

   qlm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

endmodule

// ===== hw/rtl/quadrature_length_meter_unit.sv =====
// ---------------------------------------------------------------------------
// quadrature_length_meter_unit: encoder length meter, top level
// Front intake queue, execution back end, result queue and CSR port.
// ---------------------------------------------------------------------------
// Tracks a measuring wheel from quadrature pin-change words, 100 ms tick
// words and clear words, one result word per input word in order. Each
// word passes through the back end as dequeue, speed check and result
// push; a word that closes a speed sample with a nonzero tick count adds
// the 17-bit iterative divider. The shared divider also recomputes the
// length step (circumference / pulses) after reset and after each write
// to either register, before the next word runs. Input and result queues
// are two words deep each, so intake and result draining stall on their
// own. CSR writes are always taken (csr_ready tied high) and must be
// issued while no word is in flight.
module quadrature_length_meter_unit #(
   parameter int LENGTH_MAX = qlm_pkg::LENGTH_MAX_DEF,
   parameter int IDLE_LIMIT = qlm_pkg::IDLE_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input word queue
   input  logic                              push,
   output logic                              full,
   input  logic [qlm_pkg::OP_W-1:0]          req_opcode,
   input  logic                              req_pin_a,
   input  logic                              req_pin_b,
   // result word queue
   output logic                              empty,
   input  logic                              pop,
   output logic [qlm_pkg::LEN_W-1:0]         rsp_length,
   output logic [qlm_pkg::LEN_W-1:0]         rsp_previous_length,
   output logic [qlm_pkg::RST_W-1:0]         rsp_reset_count,
   output logic [qlm_pkg::SPD_W-1:0]         rsp_speed,
   output logic                              rsp_full_relay,
   output logic                              rsp_warning_relay,
   output logic                              rsp_armed,
   // CSR write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qlm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qlm_pkg::CFG_W-1:0]         csr_data
);
   import qlm_pkg::*;

   localparam int RspW = $bits(rsp_word_type);
   localparam logic [LEN_W-1:0] LenMax = LEN_W'(LENGTH_MAX);

   csr_write_type    csr;
   logic             cmd_empty;
   logic             cmd_pop;
   cmd_kind_type     cmd_kind;
   logic             rsp_q_full;
   logic             rsp_push;
   rsp_word_type     rsp_word;
   logic [RspW-1:0]  rsp_head_bits;
   rsp_word_type     rsp_head;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   // front: classify and queue incoming words
   qlm_front #(
      .DEPTH (FIFO_DEPTH_DEF)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (push),
      .req_full   (full),
      .req_opcode (req_opcode),
      .req_pin_a  (req_pin_a),
      .req_pin_b  (req_pin_b),
      .cmd_pop    (cmd_pop),
      .cmd_empty  (cmd_empty),
      .cmd_kind   (cmd_kind)
   );

   // back: meter state, divider, result generation
   qlm_back #(
      .LENGTH_MAX (LENGTH_MAX),
      .IDLE_LIMIT (IDLE_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_empty (cmd_empty),
      .cmd_kind  (cmd_kind),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word)
   );

   // result queue toward the consumer
   qlm_fifo #(
      .WIDTH (RspW),
      .DEPTH (FIFO_DEPTH_DEF)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_word),
      .full      (rsp_q_full),
      .pop       (pop),
      .pop_data  (rsp_head_bits),
      .empty     (empty)
   );

   assign rsp_head            = rsp_word_type'(rsp_head_bits);
   assign rsp_length          = rsp_head.length;
   assign rsp_previous_length = rsp_head.previous_length;
   assign rsp_reset_count     = rsp_head.reset_count;
   assign rsp_speed           = rsp_head.speed;
   assign rsp_full_relay      = rsp_head.full_relay;
   assign rsp_warning_relay   = rsp_head.warning_relay;
   assign rsp_armed           = rsp_head.armed;

   // back end only pushes after checking queue space at dequeue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_q_full)
      else $error("result pushed into full queue");

   // a command is only taken from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command popped from empty queue");

   // each dequeued command goes through the check state before its result is pushed
   a_pop_no_quick_push: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> !rsp_push)
      else $error("result pushed right after dequeue");

   // shown results stay within range
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_length <= LenMax && rsp_speed <= SPEED_MAX))
      else $error("result length or speed out of range");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the quadrature length meter unit
// Feeds pin-change, tick and clear words through the input queue, predicts
// each meter reading in a cycle-free model and checks every popped word.
// ---------------------------------------------------------------------------
module tb;
   import qlm_pkg::*;

   localparam int unsigned WATCHDOG_CYCLES = 5000;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam logic [CSR_IDX_W-1:0] IDX_UNUSED_TOP = '1;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            pin_a;
      logic            pin_b;
   } meter_event_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // block ports
   logic                 push = 1'b0;
   logic                 full;
   logic [OP_W-1:0]      req_opcode = '0;
   logic                 req_pin_a = 1'b0;
   logic                 req_pin_b = 1'b0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [LEN_W-1:0]     rsp_length;
   logic [LEN_W-1:0]     rsp_previous_length;
   logic [RST_W-1:0]     rsp_reset_count;
   logic [SPD_W-1:0]     rsp_speed;
   logic                 rsp_full_relay;
   logic                 rsp_warning_relay;
   logic                 rsp_armed;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   quadrature_length_meter_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_opcode          (req_opcode),
      .req_pin_a           (req_pin_a),
      .req_pin_b           (req_pin_b),
      .empty               (empty),
      .pop                 (pop),
      .rsp_length          (rsp_length),
      .rsp_previous_length (rsp_previous_length),
      .rsp_reset_count     (rsp_reset_count),
      .rsp_speed           (rsp_speed),
      .rsp_full_relay      (rsp_full_relay),
      .rsp_warning_relay   (rsp_warning_relay),
      .rsp_armed           (rsp_armed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // words waiting to go in, readings waiting to come out
   meter_event_type pending_events[$];
   rsp_word_type    expected_readings[$];

   // mirror of the register file, reset values
   logic [CFG_W-1:0] cfg_target  = TARGET_RESET;
   logic [CFG_W-1:0] cfg_warning = WARNING_RESET;
   logic [CFG_W-1:0] cfg_circ    = CIRC_RESET;
   logic [CFG_W-1:0] cfg_pulses  = PULSES_RESET;

   // mirror of the meter state, all zero after reset
   logic [LEN_W-1:0]  m_len    = '0;
   logic [LEN_W-1:0]  m_saved  = '0;
   logic [RST_W-1:0]  m_resets = '0;
   logic              m_armed  = 1'b0;
   logic [CNT_W-1:0]  m_counts = '0;
   logic [TICK_W-1:0] m_ticks  = '0;
   logic [IDLE_W-1:0] m_idle   = '0;
   logic [SPD_W-1:0]  m_speed  = '0;

   int unsigned mismatches    = 0;
   int unsigned readings_seen = 0;

   // Apply one accepted word to the mirror and queue the reading it yields.
   function automatic void advance_meter(input meter_event_type w);
      logic [LEN_W-1:0] step_len;
      logic [LEN_W:0]   sum;
      int unsigned      rate;
      rsp_word_type     r;
      step_len = LEN_W'(cfg_circ / cfg_pulses);
      case (w.opcode)
         OP_PIN: begin
            if (!w.pin_a && !w.pin_b) m_armed = 1'b1;
            // (0,1) counts forward, (1,0) backward, only while armed
            if (m_armed && (w.pin_a != w.pin_b)) begin
               if (!w.pin_a) begin
                  sum = m_len + step_len;
                  if (sum > OVERSHOOT_LIMIT) m_len = '0;
                  else if (sum > LENGTH_MAX_DEF) m_len = LEN_W'(LENGTH_MAX_DEF);
                  else m_len = sum[LEN_W-1:0];
               end else begin
                  m_len = (step_len > m_len) ? '0 : m_len - step_len;
               end
               if (m_counts != '1) m_counts++;
               m_idle = '0;
            end
            if (w.pin_a && w.pin_b) m_armed = 1'b0;
         end
         OP_TICK: begin
            if (m_ticks != '1) m_ticks++;
            if (m_idle != '1) m_idle++;
         end
         OP_CLEAR: begin
            if (m_len != '0) m_saved = m_len;
            if (m_resets < RESETS_MAX) m_resets++;
            m_len = '0;
            m_speed = '0;
         end
         default: begin
         end
      endcase
      // idle timeout, then speed sample once a full turn is counted
      if (m_idle >= IDLE_LIMIT_DEF) begin
         m_counts = '0;
         m_speed = '0;
      end
      if (m_counts >= cfg_pulses) begin
         if (m_ticks == '0) rate = SPEED_MAX;
         else rate = (32'd12 * cfg_circ) / m_ticks;
         m_speed = (rate > SPEED_MAX) ? SPEED_MAX : SPD_W'(rate);
         m_counts = '0;
         m_ticks = '0;
      end
      r.length          = m_len;
      r.previous_length = m_saved;
      r.reset_count     = m_resets;
      r.speed           = m_speed;
      r.full_relay      = (int'(m_len) >= int'(cfg_target) * 100);
      r.warning_relay   = (int'(m_len) >= int'(cfg_warning) * 100);
      r.armed           = m_armed;
      expected_readings.push_back(r);
   endfunction

   task automatic report_field(input string field, input int unsigned got,
                               input int unsigned want);
      mismatches++;
      $display("tb: %s wrong at word %0d: got %0d, want %0d",
               field, readings_seen, got, want);
   endtask

   task automatic check_reading();
      rsp_word_type e;
      if (expected_readings.size() == 0) begin
         report_field("unexpected word, length", rsp_length, 0);
      end else begin
         e = expected_readings.pop_front();
         if (rsp_length !== e.length) report_field("length", rsp_length, e.length);
         if (rsp_previous_length !== e.previous_length)
            report_field("previous_length", rsp_previous_length, e.previous_length);
         if (rsp_reset_count !== e.reset_count)
            report_field("reset_count", rsp_reset_count, e.reset_count);
         if (rsp_speed !== e.speed) report_field("speed", rsp_speed, e.speed);
         if (rsp_full_relay !== e.full_relay)
            report_field("full_relay", rsp_full_relay, e.full_relay);
         if (rsp_warning_relay !== e.warning_relay)
            report_field("warning_relay", rsp_warning_relay, e.warning_relay);
         if (rsp_armed !== e.armed) report_field("armed", rsp_armed, e.armed);
      end
      readings_seen++;
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers pending_events[0] in bursts with random gaps. A word that
   // meets full stays on the ports until taken.
   // ------------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            advance_meter(pending_events.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
         if (!(push && full)) begin
            if (gap_left > 0) begin
               gap_left--;
               push <= 1'b0;
            end else if (pending_events.size() != 0) begin
               push       <= 1'b1;
               req_opcode <= pending_events[0].opcode;
               req_pin_a  <= pending_events[0].pin_a;
               req_pin_b  <= pending_events[0].pin_b;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: pops on a rotating random mask (all ones now and then), and
   // at most twice holds off for a long stretch while words are still queued so
   // the result and intake queues both back up.
   // ------------------------------------------------------------------------
   logic [31:0] stall_mask = '1;
   logic [4:0]  mask_pos   = '0;
   int unsigned mask_left  = 0;
   int unsigned hold_left  = 0;
   int unsigned holds_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_reading();
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (holds_done < 2 && readings_seen > 150 &&
                      pending_events.size() > 60) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            pop <= 1'b0;
         end else begin
            if (mask_left == 0) begin
               stall_mask = ($urandom_range(0, 2) == 0) ? '1 : $urandom;
               mask_left = $urandom_range(16, 96);
            end
            mask_left--;
            mask_pos++;
            pop <= stall_mask[mask_pos];
         end
      end
   end

   // watchdog: too long without any handshake on any port
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void add_event(input logic [OP_W-1:0] op, input logic a, input logic b);
      pending_events.push_back('{op, a, b});
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // out-of-range falls back to reset value; zero only for circ/pulses
      case (idx)
         REG_TARGET:  cfg_target  = (val > CFG_MAX) ? TARGET_RESET : val;
         REG_WARNING: cfg_warning = (val > CFG_MAX) ? WARNING_RESET : val;
         REG_CIRC:    cfg_circ    = (val > CFG_MAX || val == '0) ? CIRC_RESET : val;
         REG_PULSES:  cfg_pulses  = (val > CFG_MAX || val == '0) ? PULSES_RESET : val;
         default: begin
         end
      endcase
   endtask

   // all four registers plus two unmapped indexes (ignored by the block)
   task automatic set_config(input logic [CFG_W-1:0] target, input logic [CFG_W-1:0] warning,
                             input logic [CFG_W-1:0] circ, input logic [CFG_W-1:0] pulses);
      write_reg(REG_TARGET, target);
      write_reg(REG_WARNING, warning);
      write_reg(REG_CIRC, circ);
      write_reg(REG_PULSES, pulses);
      write_reg(IDX_UNUSED_TOP, CFG_W'($urandom));
      write_reg(CSR_IDX_W'($urandom_range(REG_PULSES + 1, IDX_UNUSED_TOP - 1)), CFG_W'($urandom));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_events.size() != 0 || expected_readings.size() != 0);
   endtask

   // Mostly clean quadrature turns (forward biased) with bounce and ticks
   // mixed in; the rest is tick runs, stray pin levels, no-ops and clears.
   task automatic queue_motion(input int unsigned count);
      int unsigned start;
      int unsigned pick;
      logic [1:0]  gray;
      logic        pa;
      logic        pb;
      bit          forward;
      start = pending_events.size();
      while (pending_events.size() - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            forward = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 6)) begin
               for (int k = 0; k < 4; k++) begin
                  // gray order 00 01 11 10; swapping A and B runs it backward
                  gray = 2'(k ^ (k >> 1));
                  pa = forward ? gray[1] : gray[0];
                  pb = forward ? gray[0] : gray[1];
                  add_event(OP_PIN, pa, pb);
                  if ($urandom_range(0, 11) == 0) add_event(OP_PIN, pa, pb);
                  if ($urandom_range(0, 9) == 0)
                     add_event(OP_TICK, 1'($urandom), 1'($urandom));
               end
            end
         end else if (pick < 84) begin
            repeat ($urandom_range(1, 12)) add_event(OP_TICK, 1'($urandom), 1'($urandom));
         end else if (pick < 93) begin
            add_event(OP_PIN, 1'($urandom), 1'($urandom));
         end else if (pick < 97) begin
            add_event(OP_NONE, 1'($urandom), 1'($urandom));
         end else begin
            add_event(OP_CLEAR, 1'($urandom), 1'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, reset config: step 125, relays at 99900 / 98900
      @(negedge clock);
      add_event(OP_PIN, 1'b1, 1'b0);    // not armed: no count
      add_event(OP_PIN, 1'b0, 1'b1);
      add_event(OP_PIN, 1'b0, 1'b0);    // arm
      add_event(OP_PIN, 1'b1, 1'b0);    // backward underflow from zero
      add_event(OP_PIN, 1'b0, 1'b1);
      add_event(OP_PIN, 1'b0, 1'b1);
      add_event(OP_TICK, 1'b1, 1'b1);   // pins ignored on a tick
      add_event(OP_PIN, 1'b0, 1'b1);
      add_event(OP_PIN, 1'b1, 1'b1);    // disarm
      add_event(OP_PIN, 1'b0, 1'b1);    // ignored while disarmed
      add_event(OP_PIN, 1'b0, 1'b0);
      add_event(OP_PIN, 1'b0, 1'b1);
      add_event(OP_NONE, 1'b1, 1'b1);
      add_event(OP_NONE, 1'b1, 1'b0);
      add_event(OP_CLEAR, 1'b0, 1'b0);  // saves nonzero length
      add_event(OP_CLEAR, 1'b1, 1'b1);  // zero length: saved value kept
      add_event(OP_PIN, 1'b1, 1'b0);
      add_event(OP_TICK, 1'b0, 1'b1);
      add_event(OP_PIN, 1'b0, 1'b1);
      add_event(OP_NONE, 1'b0, 1'b0);
      wait_drained();

      // ramp to the top from zero: 100 steps of 9999 reach 999900, then
      // step 101 saturates at the maximum and the next one overshoots to zero
      set_config(CFG_MAX, '0, CFG_MAX, CFG_W'(1));
      @(negedge clock);
      add_event(OP_CLEAR, 1'b0, 1'b0);
      add_event(OP_PIN, 1'b0, 1'b0);
      repeat (100) add_event(OP_PIN, 1'b0, 1'b1);
      wait_drained();
      set_config(CFG_MAX, '0, CFG_W'(101), CFG_W'(1));
      @(negedge clock);
      repeat (3) add_event(OP_PIN, 1'b0, 1'b1);
      add_event(OP_PIN, 1'b1, 1'b0);
      wait_drained();

      // random motion under several settings, extremes first
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_config('0, '0, CFG_W'(1), CFG_W'(1));
            1: set_config(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
            2: set_config('1, CFG_W'(10000), '0, '0);   // all fall back to reset values
            default: set_config(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 20)),
                                CFG_W'($urandom_range(1, 9999)),
                                CFG_W'($urandom_range(1, 12)));
         endcase
         @(negedge clock);
         queue_motion(95);
         // long quiet stretch: idle timeout clears the speed
         if (ph == 3) begin
            repeat (IDLE_LIMIT_DEF + 10) add_event(OP_TICK, 1'($urandom), 1'($urandom));
            queue_motion(20);
         end
         wait_drained();
      end

      // let anything stray show up before the verdict
      repeat (50) @(posedge clock);
      if (expected_readings.size() != 0)
         report_field("missing words", expected_readings.size(), 0);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
